FILE: sv/quadrature_position_speed_tracker_top_macros.svh
// ----------------------------------------------------------------------------
// Quadrature tracker assertion macros
// Concurrent checks clocked on clk and held off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_POSITION_SPEED_TRACKER_TOP_MACROS_SVH
`define QUADRATURE_POSITION_SPEED_TRACKER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define QPST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define QPST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: sv/qpst_pkg.sv
// ----------------------------------------------------------------------------
// Quadrature tracker package
// Widths, register indexes, reset values and unit control types.
// ----------------------------------------------------------------------------
`default_nettype none

package qpst_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int RES_WIDTH   = 17;
    localparam int SPEED_WIDTH = 32;
    localparam int CFG_WIDTH   = 32;
    localparam int CFG_IDX_W   = 2;

    // signed wrap-aware difference and its product with one million
    localparam int DELTA_WIDTH = 19;
    localparam int PROD_WIDTH  = 40;
    localparam int CONST_WIDTH = 20;
    localparam logic [CONST_WIDTH-1:0] US_PER_S = 20'd1000000;

    // divider: full 64-bit dividend, or a short run when the product is >= 0
    localparam int DVD_WIDTH = 64;
    localparam int DIV_LONG  = DVD_WIDTH;
    localparam int DIV_SHORT = PROD_WIDTH;
    localparam int DIV_CNT_W = 7;

    // register reset values
    localparam logic [RES_WIDTH-1:0]   RESOLUTION_RST = 17'd65536;
    localparam logic [SPEED_WIDTH-1:0] PERIOD_RST     = 32'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESOLUTION   = 2'd0,
        CFG_REVERSE      = 2'd1,
        CFG_SAMPLE_PERIOD = 2'd2,
        CFG_SPEED_ENABLE = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic start;
        logic short_op;
    } div_ctl_t;

    typedef struct packed {
        logic                   done;
        logic [SPEED_WIDTH-1:0] quotient;
    } div_res_t;

endpackage

`default_nettype wire

FILE: sv/qpst_channels.sv
// ----------------------------------------------------------------------------
// Quadrature tracker channels
// Valid/ready interfaces for observation items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface qpst_obs_if;
    logic                             valid;
    logic                             ready;
    logic                             func;
    logic [qpst_pkg::COUNT_WIDTH-1:0] raw_count;
    logic                             down_flag;
    logic                             up_flag;

    modport source (output valid, output func, output raw_count,
                    output down_flag, output up_flag, input ready);
    modport sink   (input valid, input func, input raw_count,
                    input down_flag, input up_flag, output ready);
endinterface

interface qpst_res_if;
    logic                             valid;
    logic                             ready;
    logic [qpst_pkg::COUNT_WIDTH-1:0] position;
    logic                             moving_reverse;
    logic [qpst_pkg::SPEED_WIDTH-1:0] speed;

    modport source (output valid, output position, output moving_reverse,
                    output speed, input ready);
    modport sink   (input valid, input position, input moving_reverse,
                    input speed, output ready);
endinterface

`default_nettype wire

FILE: sv/qpst_div.sv
// ----------------------------------------------------------------------------
// Quadrature tracker divider
// Restoring divider, one quotient bit per cycle, saturating to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module qpst_div (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire qpst_pkg::div_ctl_t               ctl,
    input  wire logic [qpst_pkg::DVD_WIDTH-1:0]   dividend,
    input  wire logic [qpst_pkg::SPEED_WIDTH-1:0] divisor,
    output qpst_pkg::div_res_t                    res
);

    logic [qpst_pkg::SPEED_WIDTH-1:0] rem_reg;
    logic [qpst_pkg::DVD_WIDTH-1:0]   dvd_reg;
    logic [qpst_pkg::SPEED_WIDTH-1:0] dsr_reg;
    logic [qpst_pkg::DIV_CNT_W-1:0]   cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic [qpst_pkg::SPEED_WIDTH:0]   rem_sh;
    logic [qpst_pkg::SPEED_WIDTH:0]   rem_sub;
    logic                             fits;
    logic [qpst_pkg::SPEED_WIDTH-1:0] rem_next;

    // trial subtract of the shifted partial remainder
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[qpst_pkg::DVD_WIDTH-1]};
        rem_sub  = rem_sh - {1'b0, dsr_reg};
        fits     = (rem_sh >= {1'b0, dsr_reg});
        rem_next = fits ? rem_sub[qpst_pkg::SPEED_WIDTH-1:0]
                        : rem_sh[qpst_pkg::SPEED_WIDTH-1:0];
    end

    // quotient bits shift into the low end of the dividend register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            dvd_reg  <= '0;
            dsr_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctl.start)
            begin
                rem_reg  <= '0;
                dsr_reg  <= divisor;
                busy_reg <= 1'b1;
                if (ctl.short_op)
                begin
                    dvd_reg <= {dividend[qpst_pkg::DIV_SHORT-1:0],
                                (qpst_pkg::DVD_WIDTH - qpst_pkg::DIV_SHORT)'(0)};
                    cnt_reg <= qpst_pkg::DIV_CNT_W'(qpst_pkg::DIV_SHORT);
                end
                else
                begin
                    dvd_reg <= dividend;
                    cnt_reg <= qpst_pkg::DIV_CNT_W'(qpst_pkg::DIV_LONG);
                end
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[qpst_pkg::DVD_WIDTH-2:0], fits};
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == qpst_pkg::DIV_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // saturate when any upper quotient bit is set
    always_comb
    begin
        res.done     = done_reg;
        res.quotient = (|dvd_reg[qpst_pkg::DVD_WIDTH-1:qpst_pkg::SPEED_WIDTH])
                       ? '1 : dvd_reg[qpst_pkg::SPEED_WIDTH-1:0];
    end

endmodule

`default_nettype wire

FILE: sv/quadrature_position_speed_tracker_top.sv
// ----------------------------------------------------------------------------
// Quadrature position and speed tracker
// Tracks counting direction and position; computes speed on sample items when speed is enabled.
// ----------------------------------------------------------------------------
// An observe item (func 0, or speed disabled) is answered without a wait
// state: the result is registered at the accepting edge. A speed-sample item
// passes through the multiply, divider-start, divider-wait and output states;
// the restoring divider retires one quotient bit per cycle, 40 bits when the
// count difference is non-negative and 64 when it wraps below zero. No new
// item is taken while a speed sample is in progress or while a result waits
// to be taken. Speed is counts * 1000000 / sample_period_us, saturated at 32
// bits; a zero period counts as one microsecond.
`default_nettype none

module quadrature_position_speed_tracker_top (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [qpst_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [qpst_pkg::CFG_WIDTH-1:0]     cfg_wdata,
    qpst_obs_if.sink                                obs,
    qpst_res_if.source                              result
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_START,
        ST_WAIT,
        ST_OUT
    } state_t;

    // configuration registers
    logic [qpst_pkg::RES_WIDTH-1:0]   resolution_reg;
    logic                             reverse_reg;
    logic [qpst_pkg::SPEED_WIDTH-1:0] period_reg;
    logic                             speed_en_reg;

    // tracker state and item registers
    state_t                           state_reg;
    logic                             counting_down_reg;
    logic [qpst_pkg::COUNT_WIDTH-1:0] prev_pos_reg;
    logic [qpst_pkg::SPEED_WIDTH-1:0] speed_reg;
    logic [qpst_pkg::COUNT_WIDTH-1:0] pos_reg;
    logic                             rev_reg;
    logic signed [qpst_pkg::PROD_WIDTH-1:0] product_reg;

    // output register
    logic                             out_valid_reg;
    logic [qpst_pkg::COUNT_WIDTH-1:0] out_pos_reg;
    logic                             out_rev_reg;
    logic [qpst_pkg::SPEED_WIDTH-1:0] out_speed_reg;

    logic                             out_free;
    logic                             accept;
    logic                             dir_next;
    logic [qpst_pkg::COUNT_WIDTH-1:0] pos_calc;
    logic                             rev_calc;
    logic [qpst_pkg::COUNT_WIDTH-1:0] op_a;
    logic [qpst_pkg::COUNT_WIDTH-1:0] op_b;
    logic signed [qpst_pkg::DELTA_WIDTH-1:0] counts;
    logic signed [qpst_pkg::PROD_WIDTH-1:0]  prod_calc;
    logic [qpst_pkg::SPEED_WIDTH-1:0] divisor;
    logic [qpst_pkg::DVD_WIDTH-1:0]   dividend;
    qpst_pkg::div_ctl_t               div_ctl;
    qpst_pkg::div_res_t               div_res;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resolution_reg <= qpst_pkg::RESOLUTION_RST;
            reverse_reg    <= 1'b0;
            period_reg     <= qpst_pkg::PERIOD_RST;
            speed_en_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (qpst_pkg::cfg_index_t'(cfg_index))
                qpst_pkg::CFG_RESOLUTION:
                    resolution_reg <= cfg_wdata[qpst_pkg::RES_WIDTH-1:0];
                qpst_pkg::CFG_REVERSE:       reverse_reg  <= cfg_wdata[0];
                qpst_pkg::CFG_SAMPLE_PERIOD: period_reg   <= cfg_wdata;
                qpst_pkg::CFG_SPEED_ENABLE:  speed_en_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // handshake
    assign out_free  = !out_valid_reg || result.ready;
    assign obs.ready = (state_reg == ST_IDLE) && out_free;
    assign accept    = obs.valid && obs.ready;

    // direction and position of the incoming item
    always_comb
    begin
        dir_next = (obs.down_flag != obs.up_flag) ? obs.down_flag : counting_down_reg;
        if (reverse_reg && (obs.raw_count != '0))
            pos_calc = resolution_reg[qpst_pkg::COUNT_WIDTH-1:0] - obs.raw_count;
        else
            pos_calc = obs.raw_count;
        rev_calc = dir_next ^ reverse_reg;
    end

    // wrap-aware difference in the running direction, times one million
    always_comb
    begin
        if (rev_reg)
        begin
            op_a = prev_pos_reg;
            op_b = pos_reg;
        end
        else
        begin
            op_a = pos_reg;
            op_b = prev_pos_reg;
        end
        if (op_a >= op_b)
            counts = $signed({3'b000, op_a - op_b});
        else
            counts = $signed({2'b00, resolution_reg}) - $signed({3'b000, op_b - op_a});
        prod_calc = qpst_pkg::PROD_WIDTH'(counts)
                  * qpst_pkg::PROD_WIDTH'($signed({1'b0, qpst_pkg::US_PER_S}));
    end

    // divider operands; a negative product is taken modulo 2^64
    always_comb
    begin
        divisor  = (period_reg == '0) ? qpst_pkg::SPEED_WIDTH'(1) : period_reg;
        dividend = {{(qpst_pkg::DVD_WIDTH - qpst_pkg::PROD_WIDTH)
                     {product_reg[qpst_pkg::PROD_WIDTH-1]}}, product_reg};
        div_ctl.start    = (state_reg == ST_START);
        div_ctl.short_op = !product_reg[qpst_pkg::PROD_WIDTH-1];
    end

    qpst_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (div_ctl),
        .dividend (dividend),
        .divisor  (divisor),
        .res      (div_res)
    );

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            counting_down_reg <= 1'b0;
            prev_pos_reg      <= '0;
            speed_reg         <= '0;
            pos_reg           <= '0;
            rev_reg           <= 1'b0;
            product_reg       <= '0;
            out_valid_reg     <= 1'b0;
            out_pos_reg       <= '0;
            out_rev_reg       <= 1'b0;
            out_speed_reg     <= '0;
        end
        else
        begin
            if (out_valid_reg && result.ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        counting_down_reg <= dir_next;
                        pos_reg           <= pos_calc;
                        rev_reg           <= rev_calc;
                        if (obs.func && speed_en_reg)
                            state_reg <= ST_MUL;
                        else
                        begin
                            out_valid_reg <= 1'b1;
                            out_pos_reg   <= pos_calc;
                            out_rev_reg   <= rev_calc;
                            out_speed_reg <= speed_reg;
                        end
                    end
                end
                ST_MUL:
                begin
                    product_reg <= prod_calc;
                    state_reg   <= ST_START;
                end
                ST_START:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (div_res.done)
                    begin
                        speed_reg    <= div_res.quotient;
                        prev_pos_reg <= pos_reg;
                        state_reg    <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_pos_reg   <= pos_reg;
                        out_rev_reg   <= rev_reg;
                        out_speed_reg <= speed_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.position       = out_pos_reg;
    assign result.moving_reverse = out_rev_reg;
    assign result.speed          = out_speed_reg;

endmodule

`default_nettype wire

FILE: sv/qpst_checker.sv
// ----------------------------------------------------------------------------
// Quadrature tracker checker
// Port-level checks on the observation and result channels.
// ----------------------------------------------------------------------------
`default_nettype none

`include "quadrature_position_speed_tracker_top_macros.svh"

module qpst_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             obs_valid,
    input wire logic                             obs_ready,
    input wire logic                             obs_func,
    input wire logic [qpst_pkg::COUNT_WIDTH-1:0] obs_raw_count,
    input wire logic                             res_valid,
    input wire logic                             res_ready,
    input wire logic [qpst_pkg::COUNT_WIDTH-1:0] res_position,
    input wire logic [qpst_pkg::SPEED_WIDTH-1:0] res_speed
);

    logic obs_acc;

    assign obs_acc = obs_valid && obs_ready;

    // an observe-only item is answered at once
    `QPST_ASSERT_NEXT(a_observe_latency, obs_acc && !obs_func, res_valid)

    // a zero count reports zero position, mirrored or not
    `QPST_ASSERT_NEXT(a_zero_position, obs_acc && !obs_func && (obs_raw_count == '0), res_position == '0)

    // no item taken while a result is held back
    `QPST_ASSERT_NOW(a_no_accept_when_full, res_valid && !res_ready, !obs_ready)

    // a stalled result holds
    `QPST_ASSERT_NEXT(a_result_holds, res_valid && !res_ready, res_valid && $stable(res_position) && $stable(res_speed))

endmodule

bind quadrature_position_speed_tracker_top qpst_checker u_qpst_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .obs_valid     (obs.valid),
    .obs_ready     (obs.ready),
    .obs_func      (obs.func),
    .obs_raw_count (obs.raw_count),
    .res_valid     (result.valid),
    .res_ready     (result.ready),
    .res_position  (result.position),
    .res_speed     (result.speed)
);

`default_nettype wire

FILE: tb/sv/quadrature_position_speed_tracker_top_tb.sv
// ----------------------------------------------------------------------------
// Quadrature tracker testbench
// Drives observation items through the valid/ready input channel, predicts
// position, direction and speed for each accepted item, and compares every
// result item field by field. Register settings change between phases once
// the block has gone idle; both channels idle and stall at random.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_position_speed_tracker_top_tb;

    localparam int          WATCHDOG_LIMIT = 5000;
    localparam int          RANDOM_PHASES  = 15;
    localparam int          PHASE_ITEMS    = 50;
    localparam logic [63:0] MICROS_PER_SEC = 64'd1000000;

    typedef struct packed {
        logic                             func;
        logic [qpst_pkg::COUNT_WIDTH-1:0] raw_count;
        logic                             down_flag;
        logic                             up_flag;
        logic                             drain;      // hold until all results are back
    } obs_item_t;

    typedef struct packed {
        logic [qpst_pkg::COUNT_WIDTH-1:0] position;
        logic                             moving_reverse;
        logic [qpst_pkg::SPEED_WIDTH-1:0] speed;
    } track_result_t;

    // clock, reset and channels
    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [qpst_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [qpst_pkg::CFG_WIDTH-1:0] cfg_wdata;

    qpst_obs_if obs_ch ();
    qpst_res_if res_ch ();

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    quadrature_position_speed_tracker_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .obs       (obs_ch),
        .result    (res_ch)
    );

    // register shadows
    logic [qpst_pkg::RES_WIDTH-1:0]   resolution_cfg;
    logic                             reverse_cfg;
    logic [qpst_pkg::SPEED_WIDTH-1:0] period_cfg;
    logic                             speed_en_cfg;

    // tracker state as predicted
    logic                             dir_down;
    logic [qpst_pkg::COUNT_WIDTH-1:0] last_pos;
    logic [qpst_pkg::SPEED_WIDTH-1:0] speed_val;

    obs_item_t     obs_pending_q[$];
    track_result_t track_expect_q[$];

    int  obs_outstanding;
    bit  obs_taken;
    int  tx_idle_pct;
    int  rx_stall_pct;
    int  idle_cycles;
    int  mismatch_count;
    int  items_accepted;
    int  results_checked;
    int  speed_samples;
    int  settings_count;

    // shaft walk used for well-formed motion
    int unsigned walk_pos;
    bit          walk_down;

    // position, direction and speed after one observation
    function automatic track_result_t predict_track_result(logic fn,
            logic [qpst_pkg::COUNT_WIDTH-1:0] cnt, logic dn, logic up);
        track_result_t                    r;
        logic [qpst_pkg::RES_WIDTH-1:0]   mirrored;
        logic [qpst_pkg::COUNT_WIDTH-1:0] pos;
        logic                             rev;
        logic [63:0]                      from_w;
        logic [63:0]                      to_w;
        logic [63:0]                      res_w;
        logic [63:0]                      counts;
        logic [63:0]                      period;
        logic [63:0]                      quot;
        if (dn != up)
            dir_down = dn;
        mirrored = resolution_cfg - {1'b0, cnt};
        pos = (reverse_cfg && cnt != '0) ? mirrored[qpst_pkg::COUNT_WIDTH-1:0] : cnt;
        rev = dir_down ^ reverse_cfg;
        if (fn && speed_en_cfg)
        begin
            from_w = {48'd0, last_pos};
            to_w   = {48'd0, pos};
            res_w  = {47'd0, resolution_cfg};
            // difference in the running direction, wrapping through resolution
            if (rev)
                counts = (from_w >= to_w) ? from_w - to_w : from_w + res_w - to_w;
            else
                counts = (to_w >= from_w) ? to_w - from_w : to_w + res_w - from_w;
            period    = (period_cfg == '0) ? 64'd1 : {32'd0, period_cfg};
            quot      = (counts * MICROS_PER_SEC) / period;
            last_pos  = pos;
            speed_val = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
            speed_samples++;
        end
        r.position       = pos;
        r.moving_reverse = rev;
        r.speed          = speed_val;
        return r;
    endfunction

    // one register write, shadow updated alongside
    task automatic write_reg(qpst_pkg::cfg_index_t idx,
            logic [qpst_pkg::CFG_WIDTH-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            qpst_pkg::CFG_RESOLUTION:
                resolution_cfg = data[qpst_pkg::RES_WIDTH-1:0];
            qpst_pkg::CFG_REVERSE:       reverse_cfg  = data[0];
            qpst_pkg::CFG_SAMPLE_PERIOD: period_cfg   = data;
            qpst_pkg::CFG_SPEED_ENABLE:  speed_en_cfg = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [qpst_pkg::RES_WIDTH-1:0] res, logic rev,
            logic [qpst_pkg::SPEED_WIDTH-1:0] per, logic en);
        write_reg(qpst_pkg::CFG_RESOLUTION, {15'd0, res});
        write_reg(qpst_pkg::CFG_REVERSE, {31'd0, rev});
        write_reg(qpst_pkg::CFG_SAMPLE_PERIOD, per);
        write_reg(qpst_pkg::CFG_SPEED_ENABLE, {31'd0, en});
        settings_count++;
    endtask

    task automatic queue_obs(logic fn, logic [qpst_pkg::COUNT_WIDTH-1:0] cnt,
            logic dn, logic up, logic drain);
        obs_item_t it;
        it.func      = fn;
        it.raw_count = cnt;
        it.down_flag = dn;
        it.up_flag   = up;
        it.drain     = drain;
        obs_pending_q.push_back(it);
        obs_outstanding++;
    endtask

    // block is idle once every item is in and every result is out
    task automatic wait_drained();
        while (obs_outstanding != 0 || track_expect_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_config();
        logic [qpst_pkg::RES_WIDTH-1:0]   res;
        logic [qpst_pkg::SPEED_WIDTH-1:0] per;
        case ($urandom_range(5))
            0:       res = 17'd2;
            1:       res = 17'd65536;
            2:       res = 17'($urandom_range(131071));
            default: res = 17'($urandom_range(65536, 2));
        endcase
        case ($urandom_range(5))
            0:       per = 32'd0;
            1:       per = 32'd1;
            2:       per = 32'hFFFF_FFFF;
            3:       per = $urandom;
            default: per = $urandom_range(5000, 1);
        endcase
        set_config(res, 1'($urandom_range(1)), per, $urandom_range(9) != 0);
    endtask

    // mostly shaft motion within one revolution, the rest raw noise
    task automatic queue_random_items(int n);
        int unsigned span;
        int unsigned step;
        logic        fn;
        logic        dn;
        logic        up;
        logic [15:0] cnt;
        span = (resolution_cfg >= 2 && resolution_cfg <= 65536) ? resolution_cfg : 65536;
        walk_pos = walk_pos % span;
        for (int k = 0; k < n; k++)
        begin
            fn = ($urandom_range(99) < 40);
            if ($urandom_range(99) < 80)
            begin
                dn = 1'b0;
                up = 1'b0;
                if ($urandom_range(99) < 15)
                begin
                    walk_down = !walk_down;
                    dn = walk_down;
                    up = !walk_down;
                end
                step = ($urandom_range(3) == 0) ? $urandom_range(span - 1)
                                                : $urandom_range(40);
                step = step % span;
                walk_pos = walk_down ? (walk_pos + span - step) % span
                                     : (walk_pos + step) % span;
                cnt = walk_pos[15:0];
            end
            else
            begin
                cnt = 16'($urandom);
                dn  = 1'($urandom_range(1));
                up  = 1'($urandom_range(1));
            end
            queue_obs(fn, cnt, dn, up, $urandom_range(99) < 5);
        end
    endtask

    // input driver: new item or idle at each falling edge once the last item is taken
    always @(negedge clk)
    begin : obs_driver
        obs_item_t nxt;
        logic      send;
        send = 1'b0;
        nxt  = '0;
        if (rst_n && (!obs_ch.valid || obs_taken))
        begin
            obs_taken = 1'b0;
            if (obs_pending_q.size() != 0 && $urandom_range(99) >= tx_idle_pct
                    && (!obs_pending_q[0].drain || track_expect_q.size() == 0))
            begin
                nxt  = obs_pending_q.pop_front();
                send = 1'b1;
            end
            obs_ch.valid <= send;
            if (send)
            begin
                obs_ch.func      <= nxt.func;
                obs_ch.raw_count <= nxt.raw_count;
                obs_ch.down_flag <= nxt.down_flag;
                obs_ch.up_flag   <= nxt.up_flag;
            end
        end
        res_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // monitor: check results, predict on accepted items, watchdog
    always @(posedge clk)
    begin : track_monitor
        track_result_t want;
        if (rst_n)
        begin
            idle_cycles++;
            if (res_ch.valid && res_ch.ready)
            begin
                idle_cycles = 0;
                results_checked++;
                if (track_expect_q.size() == 0)
                begin
                    $error("unexpected result item: position %0d speed %0d",
                           res_ch.position, res_ch.speed);
                    mismatch_count++;
                end
                else
                begin
                    want = track_expect_q.pop_front();
                    if (res_ch.position !== want.position)
                    begin
                        $error("position: expected %0d, actual %0d",
                               want.position, res_ch.position);
                        mismatch_count++;
                    end
                    if (res_ch.moving_reverse !== want.moving_reverse)
                    begin
                        $error("moving_reverse: expected %0d, actual %0d",
                               want.moving_reverse, res_ch.moving_reverse);
                        mismatch_count++;
                    end
                    if (res_ch.speed !== want.speed)
                    begin
                        $error("speed: expected %0d, actual %0d",
                               want.speed, res_ch.speed);
                        mismatch_count++;
                    end
                end
            end
            if (obs_ch.valid && obs_ch.ready)
            begin
                idle_cycles = 0;
                obs_taken = 1'b1;
                obs_outstanding--;
                items_accepted++;
                track_expect_q.push_back(predict_track_result(obs_ch.func,
                    obs_ch.raw_count, obs_ch.down_flag, obs_ch.up_flag));
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: nothing moved for %0d cycles", idle_cycles);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = '0;
        cfg_wdata        = '0;
        obs_ch.valid     = 1'b0;
        obs_ch.func      = 1'b0;
        obs_ch.raw_count = '0;
        obs_ch.down_flag = 1'b0;
        obs_ch.up_flag   = 1'b0;
        res_ch.ready     = 1'b0;
        resolution_cfg   = qpst_pkg::RESOLUTION_RST;
        reverse_cfg      = 1'b0;
        period_cfg       = qpst_pkg::PERIOD_RST;
        speed_en_cfg     = 1'b0;
        dir_down         = 1'b0;
        last_pos         = '0;
        speed_val        = '0;
        obs_outstanding  = 0;
        obs_taken        = 1'b0;
        idle_cycles      = 0;
        mismatch_count   = 0;
        items_accepted   = 0;
        results_checked  = 0;
        speed_samples    = 0;
        settings_count   = 1;
        walk_pos         = 0;
        walk_down        = 1'b0;
        tx_idle_pct      = 10;
        rx_stall_pct     = 88;

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: speed disabled, flags and count extremes
        queue_obs(1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
        queue_obs(1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        queue_obs(1'b0, 16'd1234, 1'b1, 1'b1, 1'b0);
        queue_obs(1'b0, 16'hA5A5, 1'b0, 1'b1, 1'b0);
        wait_drained();

        // full revolution, speed on: forward, wrap, reversal, both flags
        set_config(17'd65536, 1'b0, 32'd1000, 1'b1);
        queue_obs(1'b1, 16'd100, 1'b0, 1'b1, 1'b0);
        queue_obs(1'b1, 16'd65500, 1'b0, 1'b0, 1'b0);
        queue_obs(1'b1, 16'd20, 1'b0, 1'b0, 1'b0);
        queue_obs(1'b1, 16'd50, 1'b1, 1'b0, 1'b0);
        queue_obs(1'b1, 16'd50, 1'b1, 1'b1, 1'b1);
        wait_drained();

        // mirrored position, one-microsecond period saturates speed
        set_config(17'd65536, 1'b1, 32'd1, 1'b1);
        queue_obs(1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
        queue_obs(1'b1, 16'd1, 1'b0, 1'b0, 1'b0);
        queue_obs(1'b1, 16'hFFFF, 1'b1, 1'b0, 1'b0);
        queue_obs(1'b0, 16'h8000, 1'b0, 1'b1, 1'b0);
        wait_drained();

        // tiny revolution, zero period, counts past resolution
        set_config(17'd5, 1'b0, 32'd0, 1'b1);
        queue_obs(1'b1, 16'd3, 1'b0, 1'b1, 1'b0);
        queue_obs(1'b1, 16'd9, 1'b0, 1'b0, 1'b0);
        queue_obs(1'b1, 16'd1, 1'b1, 1'b0, 1'b0);
        queue_obs(1'b1, 16'd200, 1'b1, 1'b0, 1'b0);
        wait_drained();

        // resolution outside its range, longest period
        set_config(17'd0, 1'b1, 32'hFFFF_FFFF, 1'b1);
        queue_obs(1'b1, 16'd7, 1'b0, 1'b1, 1'b0);
        queue_obs(1'b1, 16'd0, 1'b1, 1'b0, 1'b0);
        wait_drained();
        set_config(17'h1FFFF, 1'b1, 32'd3, 1'b1);
        queue_obs(1'b1, 16'hFFFF, 1'b0, 1'b1, 1'b0);
        queue_obs(1'b1, 16'd2, 1'b1, 1'b0, 1'b0);
        queue_obs(1'b1, 16'd0, 1'b0, 1'b0, 1'b0);
        wait_drained();

        // random phases: sender idles lightly, then receiver, then neither
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < RANDOM_PHASES / 3)
            begin
                tx_idle_pct  = 10;
                rx_stall_pct = 88;
            end
            else if (ph < 2 * RANDOM_PHASES / 3)
            begin
                tx_idle_pct  = 88;
                rx_stall_pct = 10;
            end
            else
            begin
                tx_idle_pct  = 0;
                rx_stall_pct = 0;
            end
            random_config();
            queue_random_items(PHASE_ITEMS);
            wait_drained();
        end

        repeat (100) @(posedge clk);
        $display("Tracker run: %0d observation items over %0d register settings,",
                 items_accepted, settings_count);
        $display("  %0d speed samples taken, %0d result items checked.",
                 speed_samples, results_checked);
        if (mismatch_count == 0 && track_expect_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+sv
sv/qpst_pkg.sv
sv/qpst_channels.sv
sv/qpst_div.sv
sv/quadrature_position_speed_tracker_top.sv
sv/qpst_checker.sv
tb/sv/quadrature_position_speed_tracker_top_tb.sv
